>>> hw/rtl/pmd_pkg.sv
// Shared types and constants for the plasma midpoint displacement unit.
`timescale 1ns / 1ps

package pmd_pkg;

	localparam int unsigned POT_W = 16;
	localparam int unsigned COORD_W = 29;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [31:0] HASH_KEY = 32'hABCD1234;
	localparam logic [POT_W-1:0] POT_MAX = 16'hFFFF;

	typedef logic [POT_W-1:0] pot_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEED = 3'd0,
		CFG_TILEABLE = 3'd1,
		CFG_SQUASH_ACTIVE = 3'd2,
		CFG_X_GRAININESS = 3'd3,
		CFG_Y_GRAININESS = 3'd4,
		CFG_X_GRAVITY = 3'd5,
		CFG_Y_GRAVITY = 3'd6,
		CFG_FORCE_CENTRE_MAX = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic [31:0] seed;
		logic squash;
		logic [15:0] grain;
		logic [30:0] grav;
	} lane_cfg_t;

	typedef struct packed {
		logic valid;
		logic level_one;
		logic force_max;
		logic tileable;
		pot_t corner;
	} merge_ctl_t;

endpackage

>>> hw/rtl/pmd_lane.sv
// One edge-midpoint lane: hash, scramble, scale, gravity and clip over four stages.
`timescale 1ns / 1ps

module pmd_lane import pmd_pkg::*; (
	input logic clk,
	input pot_t pa,
	input pot_t pb,
	input logic [31:0] x,
	input logic [31:0] y,
	input logic [4:0] level,
	input lane_cfg_t cfg,
	output pot_t sum_s4
);

	function automatic logic [31:0] fold_coord(input logic [31:0] v);
		fold_coord = v ^ (v >> 5) ^ (v >> 10) ^ (v >> 15) ^ (v >> 20) ^ (v >> 25) ^ (v >> 30);
	endfunction

	logic [31:0] hash;
	logic [31:0] t1;
	logic [31:0] w1;
	logic [4:0] rot;
	logic zero;
	pot_t mean;

	logic [31:0] w_s1;
	logic c_s1;
	logic [4:0] rot_s1;
	logic zero_s1;
	pot_t mean_s1;
	logic [4:0] level_s1;

	logic [63:0] rot_wide;
	logic [31:0] r1;
	logic [31:0] t2;
	logic [31:0] w2;

	logic signed [14:0] rnd_s2;
	pot_t mean_s2;
	logic [4:0] level_s2;

	logic signed [16:0] grain_s;
	logic signed [31:0] prod;
	logic [5:0] gshift;
	logic [30:0] gterm;

	logic signed [31:0] prod_s3;
	logic [30:0] gterm_s3;
	pot_t mean_s3;
	logic [4:0] level_s3;

	logic signed [31:0] scaled;
	logic signed [33:0] sum;
	pot_t clipped;

	always_comb begin
		hash = {16'h0000, pa} ^ {pb, 16'h0000} ^ {x[15:0], x[31:16]} ^ y ^ cfg.seed ^ HASH_KEY;
		t1 = {1'b1, hash[31:1]} ^ (hash << 12);
		w1 = t1 ^ (t1 >> 20);
		rot = 5'(fold_coord(x) ^ fold_coord(y));
		zero = cfg.squash && (x == 32'd0) && (y == 32'd0);
		mean = 16'((17'(pa) + 17'(pb) + 17'd1) >> 1);
	end

	always_ff @(posedge clk) begin
		w_s1 <= w1;
		c_s1 <= hash[0];
		rot_s1 <= rot;
		zero_s1 <= zero;
		mean_s1 <= mean;
		level_s1 <= level;
	end

	always_comb begin
		rot_wide = {w_s1, w_s1} << rot_s1;
		r1 = rot_wide[63:32];
		t2 = {c_s1, r1[31:1]} ^ (r1 << 12);
		w2 = zero_s1 ? 32'd0 : (t2 ^ (t2 >> 20));
	end

	always_ff @(posedge clk) begin
		rnd_s2 <= $signed(w2[31:17]);
		mean_s2 <= mean_s1;
		level_s2 <= level_s1;
	end

	always_comb begin
		grain_s = $signed({1'b0, cfg.grain});
		prod = grain_s * rnd_s2;
		gshift = {level_s2, 1'b0};
		gterm = gshift[5] ? 31'd0 : (cfg.grav >> gshift[4:0]);
	end

	always_ff @(posedge clk) begin
		prod_s3 <= prod;
		gterm_s3 <= gterm;
		mean_s3 <= mean_s2;
		level_s3 <= level_s2;
	end

	always_comb begin
		scaled = prod_s3 >>> level_s3;
		sum = 34'(scaled) - $signed({3'b000, gterm_s3}) + $signed({18'h00000, mean_s3});
		if (sum < 34'sd0) begin
			clipped = '0;
		end else if (sum > $signed({18'h00000, POT_MAX})) begin
			clipped = POT_MAX;
		end else begin
			clipped = sum[POT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		sum_s4 <= clipped;
	end

endmodule

>>> hw/rtl/pmd_merge.sv
// Merge stage: registers the four midpoints and forms the centre potential.
`timescale 1ns / 1ps

module pmd_merge import pmd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input merge_ctl_t ctl,
	input pot_t bottom_mid,
	input pot_t right_mid,
	input pot_t top_mid,
	input pot_t left_mid,
	output logic done_q,
	output pot_t bottom_q,
	output pot_t right_q,
	output pot_t top_q,
	output pot_t left_q,
	output pot_t centre_q
);

	logic [POT_W+1:0] total;
	pot_t centre;

	always_comb begin
		total = 18'(bottom_mid) + 18'(right_mid) + 18'(top_mid) + 18'(left_mid) + 18'd2;
		priority if (ctl.level_one && ctl.force_max) begin
			centre = POT_MAX;
		end else if (ctl.level_one && ctl.tileable) begin
			centre = POT_MAX - ctl.corner;
		end else begin
			centre = total[POT_W+1:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		bottom_q <= bottom_mid;
		right_q <= right_mid;
		top_q <= top_mid;
		left_q <= left_mid;
		centre_q <= centre;
	end

endmodule

>>> hw/rtl/plasma_midpoint_displacement_unit.sv
// Top level of the plasma midpoint displacement unit: registers, four lanes and merge.
// A square accepted at one clock edge shows its result with done high once it has passed
// the four lane stages and the one merge stage.
// Throughput: one square per clock once busy is low, start may stay high every cycle; the receiver cannot stall.
// The fixed rate follows from each lane being a pipeline with one register per step.
// Reset clears the registers to their defaults and the pipeline to empty; busy stays
// high until the first clock edge after reset is released, then stays low.
`timescale 1ns / 1ps

module plasma_midpoint_displacement_unit import pmd_pkg::*; #(
	parameter int unsigned COORD_BITS = 28
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input coord_t left_x,
	input coord_t bottom_y,
	input coord_t right_x,
	input coord_t top_y,
	input pot_t pot_bottom_left,
	input pot_t pot_top_left,
	input pot_t pot_top_right,
	input pot_t pot_bottom_right,
	input logic [4:0] level,
	output logic done,
	output pot_t pot_bottom_mid,
	output pot_t pot_right_mid,
	output pot_t pot_top_mid,
	output pot_t pot_left_mid,
	output pot_t pot_centre
);

	localparam logic [31:0] COORD_MASK = 32'((64'd1 << COORD_BITS) - 64'd1);

	logic [31:0] seed_q;
	logic tileable_q;
	logic squash_q;
	logic [15:0] x_grain_q;
	logic [15:0] y_grain_q;
	logic [30:0] x_grav_q;
	logic [30:0] y_grav_q;
	logic force_max_q;
	logic busy_q;

	logic accept;
	logic [31:0] mask;
	logic [COORD_W:0] xsum;
	logic [COORD_W:0] ysum;
	logic [31:0] xh_m;
	logic [31:0] yh_m;
	logic [31:0] x1_m;
	logic [31:0] x2_m;
	logic [31:0] y1_m;
	logic [31:0] y2_m;
	lane_cfg_t x_cfg;
	lane_cfg_t y_cfg;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [4:0] level_s1, level_s2, level_s3, level_s4;
	pot_t corner_s1, corner_s2, corner_s3, corner_s4;

	pot_t bottom_s4, right_s4, top_s4, left_s4;
	merge_ctl_t merge_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd0;
			tileable_q <= 1'b1;
			squash_q <= 1'b0;
			x_grain_q <= 16'd8;
			y_grain_q <= 16'd8;
			x_grav_q <= 31'd0;
			y_grav_q <= 31'd0;
			force_max_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				CFG_SEED: seed_q <= cfg_data;
				CFG_TILEABLE: tileable_q <= cfg_data[0];
				CFG_SQUASH_ACTIVE: squash_q <= cfg_data[0];
				CFG_X_GRAININESS: x_grain_q <= cfg_data[15:0];
				CFG_Y_GRAININESS: y_grain_q <= cfg_data[15:0];
				CFG_X_GRAVITY: x_grav_q <= cfg_data[30:0];
				CFG_Y_GRAVITY: y_grav_q <= cfg_data[30:0];
				CFG_FORCE_CENTRE_MAX: force_max_q <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign accept = start && !busy_q;

	always_comb begin
		mask = tileable_q ? COORD_MASK : 32'hFFFF_FFFF;
		xsum = (COORD_W + 1)'(left_x) + (COORD_W + 1)'(right_x);
		ysum = (COORD_W + 1)'(bottom_y) + (COORD_W + 1)'(top_y);
		xh_m = 32'(xsum[COORD_W:1]) & mask;
		yh_m = 32'(ysum[COORD_W:1]) & mask;
		x1_m = 32'(left_x) & mask;
		x2_m = 32'(right_x) & mask;
		y1_m = 32'(bottom_y) & mask;
		y2_m = 32'(top_y) & mask;
		x_cfg = '{seed: seed_q, squash: squash_q, grain: x_grain_q, grav: x_grav_q};
		y_cfg = '{seed: seed_q, squash: squash_q, grain: y_grain_q, grav: y_grav_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		level_s1 <= level;
		level_s2 <= level_s1;
		level_s3 <= level_s2;
		level_s4 <= level_s3;
		corner_s1 <= pot_bottom_left;
		corner_s2 <= corner_s1;
		corner_s3 <= corner_s2;
		corner_s4 <= corner_s3;
	end

	pmd_lane u_lane_bottom (
		.clk(clk),
		.pa(pot_bottom_left),
		.pb(pot_bottom_right),
		.x(xh_m),
		.y(y1_m),
		.level(level),
		.cfg(x_cfg),
		.sum_s4(bottom_s4)
	);

	pmd_lane u_lane_right (
		.clk(clk),
		.pa(pot_bottom_right),
		.pb(pot_top_right),
		.x(x2_m),
		.y(yh_m),
		.level(level),
		.cfg(y_cfg),
		.sum_s4(right_s4)
	);

	pmd_lane u_lane_top (
		.clk(clk),
		.pa(pot_top_left),
		.pb(pot_top_right),
		.x(xh_m),
		.y(y2_m),
		.level(level),
		.cfg(x_cfg),
		.sum_s4(top_s4)
	);

	pmd_lane u_lane_left (
		.clk(clk),
		.pa(pot_bottom_left),
		.pb(pot_top_left),
		.x(x1_m),
		.y(yh_m),
		.level(level),
		.cfg(y_cfg),
		.sum_s4(left_s4)
	);

	always_comb begin
		merge_ctl.valid = v_s4;
		merge_ctl.level_one = (level_s4 == 5'd1);
		merge_ctl.force_max = force_max_q;
		merge_ctl.tileable = tileable_q;
		merge_ctl.corner = corner_s4;
	end

	pmd_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(merge_ctl),
		.bottom_mid(bottom_s4),
		.right_mid(right_s4),
		.top_mid(top_s4),
		.left_mid(left_s4),
		.done_q(done),
		.bottom_q(pot_bottom_mid),
		.right_q(pot_right_mid),
		.top_q(pot_top_mid),
		.left_q(pot_left_mid),
		.centre_q(pot_centre)
	);

endmodule

>>> hw/rtl/pmd_checker.sv
// Port-level checker for the plasma midpoint displacement unit, with its bind.
`timescale 1ns / 1ps

module pmd_checker import pmd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [4:0] level,
	input logic done,
	input pot_t pot_bottom_mid,
	input pot_t pot_right_mid,
	input pot_t pot_top_mid,
	input pot_t pot_left_mid,
	input pot_t pot_centre
);

	// Every result strobe comes from a matching accepted transaction.
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result strobe without a matching accepted transaction");

	// Once out of reset the unit never refuses a transaction.
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");

	// Below the top level the centre is the rounded mean of the four midpoints.
	a_centre_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(level, 5) != 5'd1)) |->
		(pot_centre == 16'((18'(pot_bottom_mid) + 18'(pot_right_mid) + 18'(pot_top_mid)
			+ 18'(pot_left_mid) + 18'd2) >> 2)))
		else $error("centre potential is not the rounded mean of the midpoints");

endmodule

bind plasma_midpoint_displacement_unit pmd_checker u_pmd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.level(level),
	.done(done),
	.pot_bottom_mid(pot_bottom_mid),
	.pot_right_mid(pot_right_mid),
	.pot_top_mid(pot_top_mid),
	.pot_left_mid(pot_left_mid),
	.pot_centre(pot_centre)
);
